// ===== src/dwrp_pkg.sv =====
// Shared types and constants for the dirty-window refresh planner.
// No dependencies; imported by every module of the block but dwrp_ram.
package dwrp_pkg;

  localparam int PAD_W   = 6;
  localparam int AREA_W  = 18;
  localparam int FRL_W   = 8;
  localparam int CFG_A_W = 2;

  localparam logic [PAD_W-1:0]  PAD_RST   = PAD_W'(8);
  localparam logic [AREA_W-1:0] AREA_RST  = AREA_W'(60000);
  localparam logic [FRL_W-1:0]  FRL_RST   = FRL_W'(6);
  localparam logic [FRL_W-1:0]  COUNT_MAX = 8'hFF;
  localparam logic [7:0]        BYTE_ONES = 8'hFF;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_PAD_PIXELS,
    CFG_PARTIAL_AREA_LIMIT,
    CFG_FAST_REFRESH_LIMIT
  } cfg_idx_t;

  // End-of-frame marker travelling with the box snapshot
  typedef struct packed {
    logic vld;
    logic force_full;
    logic any_changed;
  } snap_t;

endpackage

// ===== src/dirty_window_refresh_planner_core.sv =====
// Top level of the dirty-window refresh planner: stream ports, config
// registers, scanner and planner. Depends on dwrp_pkg, dwrp_scan, dwrp_plan.
// Throughput: one frame byte per cycle; a stalled result holds the whole
// pipeline. The last byte passes s1, s2, s3, s4 and the output register
// before the result is valid. Reset: config to defaults, box and counters
// cleared; stored bytes at or past a fill count read as all ones (no clearing pass).
module dirty_window_refresh_planner_core
  import dwrp_pkg::*;
#(
  parameter int FRAME_WIDTH  = 600,
  parameter int FRAME_HEIGHT = 400,
  localparam int XW  = $clog2(FRAME_HEIGHT + 1),
  localparam int YW  = $clog2(FRAME_WIDTH + 1),
  localparam int ODW = ((2 * XW + 2 * YW + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // frame_byte
  input  logic               in_tuser,   // force_full
  input  logic               in_tlast,   // last_byte
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [ODW-1:0]     out_tdata,  // win_x, win_y, win_w, win_h, zero fill
  output logic               out_tuser,  // do_refresh
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [AREA_W-1:0]  cfg_wdata
);

  logic              adv, in_fire;
  logic [PAD_W-1:0]  pad_r;
  logic [AREA_W-1:0] area_lim_r;
  logic [FRL_W-1:0]  frl_r;
  snap_t             snap;
  logic [XW-1:0]     snap_minx, snap_maxx, win_x, win_w;
  logic [YW-1:0]     snap_miny, snap_maxy, win_y, win_h;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign in_fire   = in_tvalid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r      <= PAD_RST;
      area_lim_r <= AREA_RST;
      frl_r      <= FRL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_PAD_PIXELS:         pad_r      <= cfg_wdata[PAD_W-1:0];
        CFG_PARTIAL_AREA_LIMIT: area_lim_r <= cfg_wdata;
        CFG_FAST_REFRESH_LIMIT: frl_r      <= cfg_wdata[FRL_W-1:0];
        default: ;
      endcase
    end
  end

  dwrp_scan #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .in_force  (in_tuser),
    .in_last   (in_tlast),
    .snap      (snap),
    .snap_minx (snap_minx),
    .snap_maxx (snap_maxx),
    .snap_miny (snap_miny),
    .snap_maxy (snap_maxy)
  );

  dwrp_plan #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_plan (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .snap        (snap),
    .snap_minx   (snap_minx),
    .snap_maxx   (snap_maxx),
    .snap_miny   (snap_miny),
    .snap_maxy   (snap_maxy),
    .pad_pixels  (pad_r),
    .area_limit  (area_lim_r),
    .fast_limit  (frl_r),
    .out_valid   (out_tvalid),
    .out_refresh (out_tuser),
    .out_x       (win_x),
    .out_y       (win_y),
    .out_w       (win_w),
    .out_h       (win_h)
  );

  assign out_tdata = ODW'({win_h, win_w, win_y, win_x});

  a_no_refresh_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("window fields not zero without refresh");

  a_win_x_in_panel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      ((XW+1)'(win_x) + (XW+1)'(win_w) <= (XW+1)'(FRAME_HEIGHT)) && (win_w != '0))
    else $error("refresh window exceeds panel width");

  a_win_y_in_panel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      ((YW+1)'(win_y) + (YW+1)'(win_h) <= (YW+1)'(FRAME_WIDTH)) && (win_h != '0))
    else $error("refresh window exceeds panel height");

endmodule

// ===== src/dwrp_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies; holds the stored frame of the planner.
module dwrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dwrp_scan.sv =====
// Byte scanner: position counters, stored-frame read-compare-write and
// changed-pixel bounding box. Depends on dwrp_pkg and dwrp_ram.
module dwrp_scan
  import dwrp_pkg::*;
#(
  parameter int FRAME_WIDTH  = 600,
  parameter int FRAME_HEIGHT = 400,
  localparam int XW = $clog2(FRAME_HEIGHT + 1),
  localparam int YW = $clog2(FRAME_WIDTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_fire,
  input  logic [7:0]    in_byte,
  input  logic          in_force,
  input  logic          in_last,
  output snap_t         snap,
  output logic [XW-1:0] snap_minx,
  output logic [XW-1:0] snap_maxx,
  output logic [YW-1:0] snap_miny,
  output logic [YW-1:0] snap_maxy
);

  localparam int ROW_BYTES   = (FRAME_WIDTH + 7) / 8;
  localparam int FRAME_BYTES = ROW_BYTES * FRAME_HEIGHT;
  localparam int AW  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int PW  = $clog2(FRAME_BYTES + 1);
  localparam int RW  = $clog2(FRAME_HEIGHT);
  localparam int CLW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int LAST_BITS = FRAME_WIDTH - 8 * (ROW_BYTES - 1);
  localparam logic [7:0] LAST_MASK = 8'(8'hFF << (8 - LAST_BITS));

  logic [PW-1:0]  pos_r, fill_r;
  logic [RW-1:0]  row_r;
  logic [CLW-1:0] col_r;
  logic           in_frame;

  logic           s1_vld_r, s1_in_r, s1_last_r, s1_force_r;
  logic           s1_fwd_r, s1_unwr_r;
  logic [7:0]     s1_byte_r, s1_fwd_data_r;
  logic [AW-1:0]  s1_addr_r;
  logic [RW-1:0]  s1_row_r;
  logic [CLW-1:0] s1_col_r;

  logic [XW-1:0]  minx_r, maxx_r;
  logic [YW-1:0]  miny_r, maxy_r;
  logic           any_r;

  logic           ram_we;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;
  logic [7:0]     old_byte, diff;
  logic [2:0]     fb, lb;
  logic           found, chg;
  logic [XW-1:0]  px;
  logic [YW-1:0]  py_lo, py_hi;

  assign in_frame  = pos_r < PW'(FRAME_BYTES);
  assign ram_we    = adv && s1_vld_r && s1_in_r;
  assign ram_raddr = adv ? pos_r[AW-1:0] : s1_addr_r;

  dwrp_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (s1_byte_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // position and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      row_r  <= '0;
      col_r  <= '0;
      fill_r <= '0;
    end else begin
      if (in_fire) begin
        if (in_last) begin
          pos_r <= '0;
          row_r <= '0;
          col_r <= '0;
        end else if (in_frame) begin
          pos_r <= pos_r + PW'(1);
          if (col_r == CLW'(ROW_BYTES - 1)) begin
            col_r <= '0;
            row_r <= row_r + RW'(1);
          end else begin
            col_r <= col_r + CLW'(1);
          end
        end
      end
      if (ram_we && (PW'(s1_addr_r) == fill_r)) begin
        fill_r <= fill_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_in_r       <= in_frame;
      s1_last_r     <= in_last;
      s1_force_r    <= in_force;
      s1_byte_r     <= in_byte;
      s1_addr_r     <= pos_r[AW-1:0];
      s1_row_r      <= row_r;
      s1_col_r      <= col_r;
      s1_fwd_r      <= ram_we && (s1_addr_r == pos_r[AW-1:0]);
      s1_fwd_data_r <= s1_byte_r;
      s1_unwr_r     <= pos_r >= fill_r;
    end
  end

  // compare against stored byte and locate changed pixels
  always_comb begin
    old_byte = s1_fwd_r ? s1_fwd_data_r : (s1_unwr_r ? BYTE_ONES : ram_rdata);
    diff = s1_byte_r ^ old_byte;
    if (s1_col_r == CLW'(ROW_BYTES - 1)) begin
      diff = diff & LAST_MASK;
    end
    chg   = s1_vld_r && s1_in_r && (diff != 8'h00);
    fb    = 3'd0;
    lb    = 3'd0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (diff[7-i]) begin
        if (!found) begin
          fb = 3'(i);
        end
        found = 1'b1;
        lb = 3'(i);
      end
    end
    px    = XW'(FRAME_HEIGHT - 1) - XW'(s1_row_r);
    py_lo = YW'({s1_col_r, 3'b000}) + YW'(fb);
    py_hi = YW'({s1_col_r, 3'b000}) + YW'(lb);

    snap_minx = (chg && (px < minx_r)) ? px : minx_r;
    snap_maxx = (chg && (px > maxx_r)) ? px : maxx_r;
    snap_miny = (chg && (py_lo < miny_r)) ? py_lo : miny_r;
    snap_maxy = (chg && (py_hi > maxy_r)) ? py_hi : maxy_r;
    snap.vld         = s1_vld_r && s1_last_r;
    snap.force_full  = s1_force_r;
    snap.any_changed = any_r || chg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minx_r <= XW'(FRAME_HEIGHT);
      maxx_r <= '0;
      miny_r <= YW'(FRAME_WIDTH);
      maxy_r <= '0;
      any_r  <= 1'b0;
    end else if (adv && s1_vld_r) begin
      if (s1_last_r) begin
        minx_r <= XW'(FRAME_HEIGHT);
        maxx_r <= '0;
        miny_r <= YW'(FRAME_WIDTH);
        maxy_r <= '0;
        any_r  <= 1'b0;
      end else begin
        minx_r <= snap_minx;
        maxx_r <= snap_maxx;
        miny_r <= snap_miny;
        maxy_r <= snap_maxy;
        any_r  <= snap.any_changed;
      end
    end
  end

endmodule

// ===== src/dwrp_plan.sv =====
// Window planner: pads and clamps the box, computes its area, picks the
// refresh window and keeps the fast-refresh count. Depends on dwrp_pkg.
module dwrp_plan
  import dwrp_pkg::*;
#(
  parameter int FRAME_WIDTH  = 600,
  parameter int FRAME_HEIGHT = 400,
  localparam int XW = $clog2(FRAME_HEIGHT + 1),
  localparam int YW = $clog2(FRAME_WIDTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  snap_t             snap,
  input  logic [XW-1:0]     snap_minx,
  input  logic [XW-1:0]     snap_maxx,
  input  logic [YW-1:0]     snap_miny,
  input  logic [YW-1:0]     snap_maxy,
  input  logic [PAD_W-1:0]  pad_pixels,
  input  logic [AREA_W-1:0] area_limit,
  input  logic [FRL_W-1:0]  fast_limit,
  output logic              out_valid,
  output logic              out_refresh,
  output logic [XW-1:0]     out_x,
  output logic [YW-1:0]     out_y,
  output logic [XW-1:0]     out_w,
  output logic [YW-1:0]     out_h
);

  localparam int XE  = ((XW > PAD_W) ? XW : PAD_W) + 1;
  localparam int YE  = ((YW > PAD_W) ? YW : PAD_W) + 1;
  localparam int ARW = XW + YW;
  localparam int ACW = (ARW > AREA_W) ? ARW : AREA_W;

  snap_t          s2_ctl_r, s3_ctl_r, s4_ctl_r;
  logic [XW-1:0]  s2_minx_r, s2_maxx_r;
  logic [YW-1:0]  s2_miny_r, s2_maxy_r;
  logic [XW-1:0]  s3_x0_r, s3_pw_r, s4_x0_r, s4_pw_r;
  logic [YW-1:0]  s3_y0_r, s3_ph_r, s4_y0_r, s4_ph_r;
  logic [ARW-1:0] s4_area_r;

  logic [XE-1:0]  x1e;
  logic [YE-1:0]  y1e;
  logic [XW-1:0]  x0, x1, pw;
  logic [YW-1:0]  y0, y1, ph;
  logic [ARW-1:0] area;

  logic             fv_r;
  logic [FRL_W-1:0] cnt_r;
  logic             full, part, refresh, whole;
  logic [XW-1:0]    wx, ww;
  logic [YW-1:0]    wy, wh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
    end else if (adv) begin
      s2_ctl_r <= snap;
      s3_ctl_r <= s2_ctl_r;
      s4_ctl_r <= s3_ctl_r;
    end
  end

  // pad and clamp
  always_comb begin
    x0  = (XE'(s2_minx_r) > XE'(pad_pixels)) ?
          XW'(XE'(s2_minx_r) - XE'(pad_pixels)) : '0;
    y0  = (YE'(s2_miny_r) > YE'(pad_pixels)) ?
          YW'(YE'(s2_miny_r) - YE'(pad_pixels)) : '0;
    x1e = XE'(s2_maxx_r) + XE'(pad_pixels);
    y1e = YE'(s2_maxy_r) + YE'(pad_pixels);
    x1  = (x1e > XE'(FRAME_HEIGHT - 1)) ? XW'(FRAME_HEIGHT - 1) : XW'(x1e);
    y1  = (y1e > YE'(FRAME_WIDTH - 1)) ? YW'(FRAME_WIDTH - 1) : YW'(y1e);
    pw  = x1 - x0 + XW'(1);
    ph  = y1 - y0 + YW'(1);
  end

  assign area = ARW'(s3_pw_r) * ARW'(s3_ph_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_minx_r <= snap_minx;
      s2_maxx_r <= snap_maxx;
      s2_miny_r <= snap_miny;
      s2_maxy_r <= snap_maxy;
      s3_x0_r   <= x0;
      s3_y0_r   <= y0;
      s3_pw_r   <= pw;
      s3_ph_r   <= ph;
      s4_x0_r   <= s3_x0_r;
      s4_y0_r   <= s3_y0_r;
      s4_pw_r   <= s3_pw_r;
      s4_ph_r   <= s3_ph_r;
      s4_area_r <= area;
    end
  end

  // window choice
  always_comb begin
    full    = s4_ctl_r.force_full || !fv_r;
    part    = !full && s4_ctl_r.any_changed && (cnt_r < fast_limit) &&
              (ACW'(s4_area_r) <= ACW'(area_limit));
    refresh = full || s4_ctl_r.any_changed;
    wx = part ? s4_x0_r : '0;
    wy = part ? s4_y0_r : '0;
    ww = part ? s4_pw_r : XW'(FRAME_HEIGHT);
    wh = part ? s4_ph_r : YW'(FRAME_WIDTH);
    if (!refresh) begin
      wx = '0;
      wy = '0;
      ww = '0;
      wh = '0;
    end
    whole = (wx == '0) && (wy == '0) &&
            (ww == XW'(FRAME_HEIGHT)) && (wh == YW'(FRAME_WIDTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r      <= 1'b0;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s4_ctl_r.vld;
      if (s4_ctl_r.vld && refresh) begin
        fv_r <= 1'b1;
        if (whole) begin
          cnt_r <= '0;
        end else if (cnt_r != COUNT_MAX) begin
          cnt_r <= cnt_r + FRL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s4_ctl_r.vld) begin
      out_refresh <= refresh;
      out_x       <= wx;
      out_y       <= wy;
      out_w       <= ww;
      out_h       <= wh;
    end
  end

endmodule

// ===== tb/tb_dirty_window_refresh_planner_core.sv =====
// Self-checking testbench for dirty_window_refresh_planner_core: streams frames,
// predicts each refresh window in SystemVerilog and checks every result beat.
// Depends on dwrp_pkg and the core RTL only.
module tb_dirty_window_refresh_planner_core
  import dwrp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_WIDTH  = 600;
  localparam int FRAME_HEIGHT = 400;
  localparam int ROW_BYTES    = (FRAME_WIDTH + 7) / 8;
  localparam int FRAME_BYTES  = ROW_BYTES * FRAME_HEIGHT;
  localparam int PANEL_W      = FRAME_HEIGHT;
  localparam int PANEL_H      = FRAME_WIDTH;

  typedef struct packed {
    logic [7:0] pixels;
    logic       force_full;
    logic       last;
  } pixel_beat_t;

  typedef struct {
    bit       refresh;
    bit [8:0] x;
    bit [9:0] y;
    bit [8:0] w;
    bit [9:0] h;
  } window_t;

  typedef enum int {KIND_SAME, KIND_SPARSE, KIND_NOISE} frame_kind_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;   // frame_byte
  logic                in_tuser = 1'b0; // force_full
  logic                in_tlast = 1'b0; // last_byte
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [39:0]         out_tdata;       // win_x, win_y, win_w, win_h, zero fill
  logic                out_tuser;       // do_refresh
  logic                cfg_we = 1'b0;
  logic [CFG_A_W-1:0]  cfg_addr = '0;
  logic [AREA_W-1:0]   cfg_wdata = '0;

  dirty_window_refresh_planner_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [7:0]        stored_frame [FRAME_BYTES];
  int                scan_pos = 0;
  bit                frame_ok = 1'b0;
  logic [FRL_W-1:0]  fast_count = '0;
  int                box_x0 = PANEL_W;
  int                box_x1 = 0;
  int                box_y0 = PANEL_H;
  int                box_y1 = 0;
  bit                box_hit = 1'b0;
  logic [PAD_W-1:0]  pad_cfg = PAD_RST;
  logic [AREA_W-1:0] area_cfg = AREA_RST;
  logic [FRL_W-1:0]  limit_cfg = FRL_RST;

  // Stimulus-side copy of the stored frame
  logic [7:0]        shadow_frame [FRAME_BYTES];

  pixel_beat_t       pending_beats [$];
  window_t           expected_windows [$];
  pixel_beat_t       sent_beat;
  window_t           want_win;
  int                errors = 0;
  int                results_seen = 0;
  longint            run_budget = 0;
  longint            cycle_count = 0;

  int                send_gap = 0;
  int                send_mode_left = 0;
  bit                send_steady = 1'b0;
  int                recv_gap = 0;
  int                recv_mode_left = 0;
  bit                recv_steady = 1'b0;
  int                stall_left = 0;
  int                next_stall_at = 3;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic plan_window(input pixel_beat_t b);
    int row, col, lx, px, i;
    int x0, y0, x1, y1, pw, ph;
    int wx, wy, ww, wh;
    bit refresh;
    logic [7:0] diff;
    window_t win;
    if (scan_pos < FRAME_BYTES) begin
      row = scan_pos / ROW_BYTES;
      col = scan_pos % ROW_BYTES;
      diff = b.pixels ^ stored_frame[scan_pos];
      for (i = 0; i < 8; i++) begin
        lx = col * 8 + i;
        if (lx < FRAME_WIDTH && diff[7-i]) begin
          px = FRAME_HEIGHT - 1 - row;
          if (px < box_x0) box_x0 = px;
          if (px > box_x1) box_x1 = px;
          if (lx < box_y0) box_y0 = lx;
          if (lx > box_y1) box_y1 = lx;
          box_hit = 1'b1;
        end
      end
      stored_frame[scan_pos] = b.pixels;
      scan_pos++;
    end
    if (b.last) begin
      refresh = 1'b1;
      wx = 0;
      wy = 0;
      ww = PANEL_W;
      wh = PANEL_H;
      if (!b.force_full && frame_ok) begin
        if (!box_hit) begin
          refresh = 1'b0;
        end else if (fast_count < limit_cfg) begin
          x0 = (box_x0 > pad_cfg) ? box_x0 - pad_cfg : 0;
          y0 = (box_y0 > pad_cfg) ? box_y0 - pad_cfg : 0;
          x1 = box_x1 + pad_cfg;
          y1 = box_y1 + pad_cfg;
          if (x1 > PANEL_W - 1) x1 = PANEL_W - 1;
          if (y1 > PANEL_H - 1) y1 = PANEL_H - 1;
          pw = x1 - x0 + 1;
          ph = y1 - y0 + 1;
          if (pw * ph <= area_cfg) begin
            wx = x0;
            wy = y0;
            ww = pw;
            wh = ph;
          end
        end
      end
      if (refresh) begin
        if (wx == 0 && wy == 0 && ww == PANEL_W && wh == PANEL_H) fast_count = '0;
        else if (fast_count < COUNT_MAX) fast_count++;
        frame_ok = 1'b1;
      end else begin
        wx = 0;
        wy = 0;
        ww = 0;
        wh = 0;
      end
      win.refresh = refresh;
      win.x = 9'(wx);
      win.y = 10'(wy);
      win.w = 9'(ww);
      win.h = 10'(wh);
      expected_windows.push_back(win);
      box_x0 = PANEL_W;
      box_x1 = 0;
      box_y0 = PANEL_H;
      box_y1 = 0;
      box_hit = 1'b0;
      scan_pos = 0;
    end
  endtask

  task automatic queue_frame(int len, frame_kind_t kind, bit force_last, int flip_at,
                             logic [7:0] flip_mask);
    pixel_beat_t beat;
    logic [7:0] b;
    int i, k;
    for (i = 0; i < len; i++) begin
      b = (i < FRAME_BYTES) ? shadow_frame[i] : 8'($urandom);
      if (kind == KIND_SPARSE && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(0, 7);
        b[k] = ~b[k];
      end else if (kind == KIND_NOISE) begin
        b = 8'($urandom);
      end
      if (i == flip_at) b = b ^ flip_mask;
      if (i < FRAME_BYTES) shadow_frame[i] = b;
      beat.pixels = b;
      beat.last = (i == len - 1);
      beat.force_full = beat.last ? force_last : ($urandom_range(0, 3) == 0);
      pending_beats.push_back(beat);
      run_budget += 80;
    end
    run_budget += 600;
  endtask

  task automatic random_frames(int n_items);
    int total, len, r;
    frame_kind_t kind;
    total = 0;
    while (total < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 12);
      else if (r < 92) len = $urandom_range(13, 40);
      else len = $urandom_range(60, 90);
      r = $urandom_range(0, 9);
      kind = (r < 2) ? KIND_SAME : (r < 7) ? KIND_SPARSE : KIND_NOISE;
      queue_frame(len, kind, $urandom_range(0, 6) == 0, -1, 8'h00);
      total += len;
    end
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_tvalid || expected_windows.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_config(int unsigned pad, int unsigned area, int unsigned lim);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_PAD_PIXELS;
    cfg_wdata <= AREA_W'(pad);
    @(posedge clk);
    cfg_addr <= CFG_PARTIAL_AREA_LIMIT;
    cfg_wdata <= AREA_W'(area);
    @(posedge clk);
    cfg_addr <= CFG_FAST_REFRESH_LIMIT;
    cfg_wdata <= AREA_W'(lim);
    @(posedge clk);
    cfg_we <= 1'b0;
    pad_cfg = PAD_W'(pad);
    area_cfg = AREA_W'(area);
    limit_cfg = FRL_W'(lim);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) plan_window(sent_beat);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          sent_beat = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= sent_beat.pixels;
          in_tuser <= sent_beat.force_full;
          in_tlast <= sent_beat.last;
          if (send_mode_left == 0) begin
            send_steady = ($urandom_range(0, 3) == 0);
            send_mode_left = $urandom_range(50, 300);
          end else begin
            send_mode_left--;
          end
          send_gap = send_steady ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (results_seen >= next_stall_at) begin
      next_stall_at += 40;
      stall_left = 300;
      out_tready <= 1'b0;
    end else begin
      if (recv_mode_left == 0) begin
        recv_steady = ($urandom_range(0, 3) == 0);
        recv_mode_left = $urandom_range(50, 400);
      end else begin
        recv_mode_left--;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else if (!recv_steady && $urandom_range(0, 4) == 0) begin
        recv_gap = pick_gap();
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (expected_windows.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual tdata=%h tuser=%b",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want_win = expected_windows.pop_front();
        check_field("do_refresh", want_win.refresh, out_tuser);
        check_field("win_x", want_win.x, out_tdata[8:0]);
        check_field("win_y", want_win.y, out_tdata[18:9]);
        check_field("win_w", want_win.w, out_tdata[27:19]);
        check_field("win_h", want_win.h, out_tdata[37:28]);
        check_field("tdata fill", 0, out_tdata[39:38]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 3 * run_budget + 50000) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("** dirty_window_refresh_planner_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < FRAME_BYTES; i++) begin
      stored_frame[i] = 8'hFF;
      shadow_frame[i] = 8'hFF;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    queue_frame(1, KIND_SAME, 1'b0, 0, 8'hFF);
    queue_frame(1, KIND_SAME, 1'b0, -1, 8'h00);
    queue_frame(1, KIND_SAME, 1'b1, -1, 8'h00);
    queue_frame(2, KIND_SAME, 1'b0, 0, 8'h80);
    queue_frame(ROW_BYTES, KIND_SAME, 1'b0, ROW_BYTES - 1, 8'h01);
    queue_frame(3, KIND_NOISE, 1'b0, -1, 8'h00);
    random_frames(200);
    wait_idle();

    apply_config(63, 240000, 255);
    for (i = 0; i < 260; i++) queue_frame(1, KIND_SAME, 1'b0, 0, 8'($urandom_range(1, 255)));
    random_frames(40);
    wait_idle();

    apply_config(0, 0, 0);
    random_frames(100);
    wait_idle();

    apply_config(0, 1, 1);
    random_frames(100);

    for (i = 0; i < 3; i++) begin
      wait_idle();
      apply_config($urandom_range(0, 63),
                   $urandom_range(0, 1) ? $urandom_range(0, 240000) : $urandom_range(0, 3000),
                   $urandom_range(0, 8));
      random_frames(110);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** dirty_window_refresh_planner_core: PASSED **");
    end else begin
      $display("** dirty_window_refresh_planner_core: FAILED **");
    end
    $finish;
  end

endmodule
